[hw/rtl/mrfp_pkg.sv]
// Shared constants, codes and types of the motor reply frame parser.
package mrfp_pkg;

	localparam int MAX_REPLY_BYTES_DEF = 16;
	localparam int KEPT_BYTES = 7;

	localparam logic [7:0] FN_OPTIONS  = 8'h1A;
	localparam logic [7:0] FN_VERSION  = 8'h1F;
	localparam logic [7:0] FN_MOVE     = 8'hFD;
	localparam logic [7:0] FN_STOP     = 8'hFE;
	localparam logic [7:0] FN_POSITION = 8'h36;
	localparam logic [7:0] FN_STATUS   = 8'h3A;
	localparam logic [7:0] CODE_PARAM  = 8'hE2;
	localparam logic [7:0] CODE_FORMAT = 8'hEE;
	localparam logic [7:0] CODE_REACH  = 8'h9F;
	localparam logic [7:0] CODE_ACK    = 8'h02;
	localparam logic [7:0] STATUS_RSVD = 8'h40;

	localparam logic [7:0] ADDRESS_RESET  = 8'h01;
	localparam logic [7:0] FUNCTION_RESET = 8'h3A;
	localparam logic [7:0] CHECK_RESET    = 8'h6B;

	localparam logic [1:0] CFG_ADDRESS  = 2'd0;
	localparam logic [1:0] CFG_FUNCTION = 2'd1;
	localparam logic [1:0] CFG_CHECK    = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_PROTO = 2'd1;
	localparam logic [1:0] ST_DEV   = 2'd2;

	localparam logic [3:0] K_NONE    = 4'd0;
	localparam logic [3:0] K_ACK     = 4'd1;
	localparam logic [3:0] K_REACHED = 4'd2;
	localparam logic [3:0] K_PARAM   = 4'd3;
	localparam logic [3:0] K_FORMAT  = 4'd4;
	localparam logic [3:0] K_OPTIONS = 4'd5;
	localparam logic [3:0] K_STATUS  = 4'd6;
	localparam logic [3:0] K_POS     = 4'd7;
	localparam logic [3:0] K_VERSION = 4'd8;

	typedef enum logic [2:0] {
		FC_UNKNOWN,
		FC_OPTIONS,
		FC_STATUS,
		FC_POSITION,
		FC_VERSION,
		FC_MOVE,
		FC_STOP
	} fn_class_t;

	typedef struct packed {
		logic            hdr_ok;
		fn_class_t       fn_class;
		logic            len_is4;
		logic            len_is5;
		logic            len_is7;
		logic            len_is8;
		logic [4:0]      frame_length;
		logic [4:0][7:0] payload;
	} frame_rec_t;

	typedef struct packed {
		logic [1:0]  result_status;
		logic [3:0]  reply_kind;
		logic [4:0]  frame_length;
		logic [15:0] option_flags;
		logic [7:0]  status_bits;
		logic        position_negative;
		logic [31:0] position_magnitude;
		logic [15:0] fw_version;
		logic [3:0]  hw_series;
		logic [3:0]  hw_model;
		logic [7:0]  hw_revision;
	} reply_t;

endpackage

[hw/rtl/mrfp_front.sv]
// Front end: byte counter, kept-byte store and frame header checks.
module mrfp_front #(
	parameter int MAX_REPLY_BYTES = mrfp_pkg::MAX_REPLY_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic [7:0]          match_address,
	input  logic [7:0]          pending_function,
	input  logic [7:0]          check_byte,
	input  logic                space,
	output logic                push,
	output mrfp_pkg::frame_rec_t rec
);
	import mrfp_pkg::*;

	localparam int CNT_W = $clog2(MAX_REPLY_BYTES + 2);

	logic [CNT_W-1:0]   count_q;
	logic [7:0]         bytes_q [KEPT_BYTES];
	logic               accept;
	logic [CNT_W-1:0]   len_full;
	logic [CNT_W+4:0]   len_ext;
	fn_class_t          fn_class;

	assign in_ready = space;
	assign accept   = in_valid & space;
	assign push     = accept & last_byte;

	assign len_full = (count_q <= CNT_W'(MAX_REPLY_BYTES)) ? count_q + CNT_W'(1) : count_q;
	assign len_ext  = (CNT_W + 5)'(len_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				count_q <= '0;
			end else begin
				count_q <= len_full;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < KEPT_BYTES; i++) begin
			if (accept && count_q == CNT_W'(i)) begin
				bytes_q[i] <= data_byte;
			end
		end
	end

	always_comb begin
		unique case (pending_function)
			FN_OPTIONS:  fn_class = FC_OPTIONS;
			FN_STATUS:   fn_class = FC_STATUS;
			FN_POSITION: fn_class = FC_POSITION;
			FN_VERSION:  fn_class = FC_VERSION;
			FN_MOVE:     fn_class = FC_MOVE;
			FN_STOP:     fn_class = FC_STOP;
			default:     fn_class = FC_UNKNOWN;
		endcase
	end

	always_comb begin
		rec.hdr_ok = (len_full >= CNT_W'(4)) && (len_full <= CNT_W'(MAX_REPLY_BYTES))
			&& (bytes_q[0] == match_address) && (bytes_q[1] == pending_function)
			&& (data_byte == check_byte);
		rec.fn_class     = fn_class;
		rec.len_is4      = (len_full == CNT_W'(4));
		rec.len_is5      = (len_full == CNT_W'(5));
		rec.len_is7      = (len_full == CNT_W'(7));
		rec.len_is8      = (len_full == CNT_W'(8));
		rec.frame_length = len_ext[4:0];
		for (int i = 0; i < 5; i++) begin
			rec.payload[i] = bytes_q[i + 2];
		end
	end

endmodule

[hw/rtl/mrfp_queue.sv]
// Two-entry queue that carries checked frame records from front to back.
module mrfp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mrfp_pkg::frame_rec_t push_data,
	output logic                 space,
	input  logic                 pop,
	output logic                 head_valid,
	output mrfp_pkg::frame_rec_t head_data
);
	import mrfp_pkg::*;

	frame_rec_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign space      = (fill_q != 2'd2);
	assign head_valid = (fill_q != 2'd0);
	assign head_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[hw/rtl/mrfp_back.sv]
// Back end: decodes a frame record into a reply and holds it in the output register.
module mrfp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  mrfp_pkg::frame_rec_t head_data,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mrfp_pkg::reply_t     reply
);
	import mrfp_pkg::*;

	logic       out_valid_q;
	reply_t     reply_q;
	reply_t     next_reply;
	logic [7:0] d2;

	assign d2        = head_data.payload[0];
	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign reply     = reply_q;

	always_comb begin
		next_reply               = '0;
		next_reply.result_status = ST_PROTO;
		next_reply.reply_kind    = K_NONE;
		next_reply.frame_length  = head_data.frame_length;
		if (head_data.hdr_ok && head_data.fn_class != FC_UNKNOWN) begin
			if (head_data.len_is4 && d2 == CODE_PARAM) begin
				next_reply.result_status = ST_DEV;
				next_reply.reply_kind    = K_PARAM;
			end else if (head_data.len_is4 && d2 == CODE_FORMAT) begin
				next_reply.result_status = ST_DEV;
				next_reply.reply_kind    = K_FORMAT;
			end else begin
				unique case (head_data.fn_class)
					FC_OPTIONS: begin
						if (head_data.len_is5) begin
							next_reply.result_status = ST_OK;
							next_reply.reply_kind    = K_OPTIONS;
							next_reply.option_flags  = {d2, head_data.payload[1]};
						end
					end
					FC_STATUS: begin
						if (head_data.len_is4 && (d2 & STATUS_RSVD) == 8'h00) begin
							next_reply.result_status = ST_OK;
							next_reply.reply_kind    = K_STATUS;
							next_reply.status_bits   = d2;
						end
					end
					FC_POSITION: begin
						if (head_data.len_is8 && d2[7:1] == 7'd0) begin
							next_reply.result_status      = ST_OK;
							next_reply.reply_kind         = K_POS;
							next_reply.position_negative  = d2[0];
							next_reply.position_magnitude = {head_data.payload[1],
								head_data.payload[2], head_data.payload[3], head_data.payload[4]};
						end
					end
					FC_VERSION: begin
						if (head_data.len_is7) begin
							next_reply.result_status = ST_OK;
							next_reply.reply_kind    = K_VERSION;
							next_reply.fw_version    = {d2, head_data.payload[1]};
							next_reply.hw_series     = head_data.payload[2][7:4];
							next_reply.hw_model      = head_data.payload[2][3:0];
							next_reply.hw_revision   = head_data.payload[3];
						end
					end
					FC_MOVE, FC_STOP: begin
						if (head_data.len_is4) begin
							if (d2 == CODE_ACK) begin
								next_reply.result_status = ST_OK;
								next_reply.reply_kind    = K_ACK;
							end else if (head_data.fn_class == FC_MOVE && d2 == CODE_REACH) begin
								next_reply.result_status = ST_OK;
								next_reply.reply_kind    = K_REACHED;
							end
						end
					end
					default: begin
						next_reply.result_status = ST_PROTO;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			reply_q <= next_reply;
		end
	end

endmodule

[hw/rtl/motor_reply_frame_parser_unit.sv]
// Top level of the motor reply frame parser: configuration registers and the three stages.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_ready  data_byte, last_byte
//   out       output     out_valid/out_ready  result_status .. hw_revision
//   cfg       input      cfg_we               cfg_index, cfg_data
//
// One beat is accepted every cycle while the two-entry queue has room.
// A frame's record is registered in the queue, then its reply in the output register.
// Reset clears the byte counter, the queue and the output valid; configuration returns
// to its reset values. Output stalls fill the queue and then hold off in_ready.
module motor_reply_frame_parser_unit #(
	parameter int MAX_REPLY_BYTES = mrfp_pkg::MAX_REPLY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_status,
	output logic [3:0]  reply_kind,
	output logic [4:0]  frame_length,
	output logic [15:0] option_flags,
	output logic [7:0]  status_bits,
	output logic        position_negative,
	output logic [31:0] position_magnitude,
	output logic [15:0] fw_version,
	output logic [3:0]  hw_series,
	output logic [3:0]  hw_model,
	output logic [7:0]  hw_revision,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import mrfp_pkg::*;

	logic [7:0] match_address_q;
	logic [7:0] pending_function_q;
	logic [7:0] check_byte_q;
	logic       space;
	logic       push;
	logic       pop;
	logic       head_valid;
	frame_rec_t push_rec;
	frame_rec_t head_rec;
	reply_t     reply;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_address_q    <= ADDRESS_RESET;
			pending_function_q <= FUNCTION_RESET;
			check_byte_q       <= CHECK_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ADDRESS) begin
				match_address_q <= cfg_data;
			end
			if (cfg_index == CFG_FUNCTION) begin
				pending_function_q <= cfg_data;
			end
			if (cfg_index == CFG_CHECK) begin
				check_byte_q <= cfg_data;
			end
		end
	end

	mrfp_front #(
		.MAX_REPLY_BYTES(MAX_REPLY_BYTES)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_byte       (data_byte),
		.last_byte       (last_byte),
		.match_address   (match_address_q),
		.pending_function(pending_function_q),
		.check_byte      (check_byte_q),
		.space           (space),
		.push            (push),
		.rec             (push_rec)
	);

	mrfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_rec),
		.space     (space),
		.pop       (pop),
		.head_valid(head_valid),
		.head_data (head_rec)
	);

	mrfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_data (head_rec),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.reply     (reply)
	);

	assign result_status      = reply.result_status;
	assign reply_kind         = reply.reply_kind;
	assign frame_length       = reply.frame_length;
	assign option_flags       = reply.option_flags;
	assign status_bits        = reply.status_bits;
	assign position_negative  = reply.position_negative;
	assign position_magnitude = reply.position_magnitude;
	assign fw_version         = reply.fw_version;
	assign hw_series          = reply.hw_series;
	assign hw_model           = reply.hw_model;
	assign hw_revision        = reply.hw_revision;

endmodule

[hw/rtl/mrfp_checker.sv]
// Port-level checks of the motor reply frame parser and their binding to the top level.
module mrfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  result_status,
	input logic [3:0]  reply_kind,
	input logic [4:0]  frame_length,
	input logic [15:0] option_flags,
	input logic [7:0]  status_bits,
	input logic [31:0] position_magnitude,
	input logic [15:0] fw_version
);
	import mrfp_pkg::*;

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Reply beat dropped before it was taken.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (result_status == ST_OK || result_status == ST_PROTO
			|| result_status == ST_DEV))
		else $error("Result status outside its codes.");

	a_ok_has_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_status == ST_OK |-> reply_kind != K_NONE)
		else $error("Good reply without a kind.");

	a_dev_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_status == ST_DEV |->
			frame_length == 5'd4 && (reply_kind == K_PARAM || reply_kind == K_FORMAT))
		else $error("Device error on a frame that is not four bytes long.");

	a_error_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_status != ST_OK |-> option_flags == 16'd0
			&& status_bits == 8'd0 && position_magnitude == 32'd0
			&& fw_version == 16'd0)
		else $error("Failed reply carries data.");

endmodule

bind motor_reply_frame_parser_unit mrfp_checker u_mrfp_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.result_status     (result_status),
	.reply_kind        (reply_kind),
	.frame_length      (frame_length),
	.option_flags      (option_flags),
	.status_bits       (status_bits),
	.position_magnitude(position_magnitude),
	.fw_version        (fw_version)
);

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the motor reply frame parser, checked against a predictor.
import mrfp_pkg::*;

class reply_board;
	logic [7:0] dev_addr;
	logic [7:0] dev_func;
	logic [7:0] tail_byte;
	logic [4:0] byte_cnt;
	logic [7:0] kept [KEPT_BYTES];
	reply_t pending_replies[$];
	int errors;
	int checked;
	int n_ok;
	int n_proto;
	int n_dev;

	function new();
		dev_addr = ADDRESS_RESET;
		dev_func = FUNCTION_RESET;
		tail_byte = CHECK_RESET;
		byte_cnt = '0;
		foreach (kept[i]) kept[i] = '0;
		errors = 0;
		checked = 0;
		n_ok = 0;
		n_proto = 0;
		n_dev = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [7:0] val);
		case (idx)
			CFG_ADDRESS: dev_addr = val;
			CFG_FUNCTION: dev_func = val;
			CFG_CHECK: tail_byte = val;
			default: ;
		endcase
	endfunction

	// Notes one accepted beat and queues the reply that a final beat produces.
	function void note_beat(logic [7:0] b, logic last);
		reply_t r;
		logic [4:0] len;
		logic known;
		if (byte_cnt < KEPT_BYTES) kept[byte_cnt] = b;
		if (byte_cnt < MAX_REPLY_BYTES_DEF + 1) byte_cnt++;
		if (!last) return;
		len = byte_cnt;
		byte_cnt = '0;
		r = '0;
		r.result_status = ST_PROTO;
		r.reply_kind = K_NONE;
		r.frame_length = len;
		case (dev_func)
			FN_OPTIONS, FN_STATUS, FN_POSITION, FN_VERSION, FN_MOVE, FN_STOP: known = 1'b1;
			default: known = 1'b0;
		endcase
		if (known && len >= 4 && len <= MAX_REPLY_BYTES_DEF && kept[0] == dev_addr &&
				kept[1] == dev_func && b == tail_byte) begin
			if (len == 4 && kept[2] == CODE_PARAM) begin
				r.result_status = ST_DEV;
				r.reply_kind = K_PARAM;
			end else if (len == 4 && kept[2] == CODE_FORMAT) begin
				r.result_status = ST_DEV;
				r.reply_kind = K_FORMAT;
			end else begin
				case (dev_func)
					FN_OPTIONS: if (len == 5) begin
						r.result_status = ST_OK;
						r.reply_kind = K_OPTIONS;
						r.option_flags = {kept[2], kept[3]};
					end
					FN_STATUS: if (len == 4 && (kept[2] & STATUS_RSVD) == 8'h00) begin
						r.result_status = ST_OK;
						r.reply_kind = K_STATUS;
						r.status_bits = kept[2];
					end
					FN_POSITION: if (len == 8 && kept[2] <= 8'd1) begin
						r.result_status = ST_OK;
						r.reply_kind = K_POS;
						r.position_negative = kept[2][0];
						r.position_magnitude = {kept[3], kept[4], kept[5], kept[6]};
					end
					FN_VERSION: if (len == 7) begin
						r.result_status = ST_OK;
						r.reply_kind = K_VERSION;
						r.fw_version = {kept[2], kept[3]};
						r.hw_series = kept[4][7:4];
						r.hw_model = kept[4][3:0];
						r.hw_revision = kept[5];
					end
					default: if (len == 4) begin
						if (kept[2] == CODE_ACK) begin
							r.result_status = ST_OK;
							r.reply_kind = K_ACK;
						end else if (dev_func == FN_MOVE && kept[2] == CODE_REACH) begin
							r.result_status = ST_OK;
							r.reply_kind = K_REACHED;
						end
					end
				endcase
			end
		end
		pending_replies.push_back(r);
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	function void check_reply(reply_t got);
		reply_t want;
		if (pending_replies.size() == 0) begin
			$error("reply beat arrived with no frame outstanding");
			errors++;
			return;
		end
		want = pending_replies.pop_front();
		checked++;
		case (want.result_status)
			ST_OK: n_ok++;
			ST_DEV: n_dev++;
			default: n_proto++;
		endcase
		compare_field("result_status", want.result_status, got.result_status);
		compare_field("reply_kind", want.reply_kind, got.reply_kind);
		compare_field("frame_length", want.frame_length, got.frame_length);
		compare_field("option_flags", want.option_flags, got.option_flags);
		compare_field("status_bits", want.status_bits, got.status_bits);
		compare_field("position_negative", want.position_negative, got.position_negative);
		compare_field("position_magnitude", want.position_magnitude, got.position_magnitude);
		compare_field("fw_version", want.fw_version, got.fw_version);
		compare_field("hw_series", want.hw_series, got.hw_series);
		compare_field("hw_model", want.hw_model, got.hw_model);
		compare_field("hw_revision", want.hw_revision, got.hw_revision);
	endfunction
endclass

module tb;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TARGET_BEATS = 1200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  result_status;
	logic [3:0]  reply_kind;
	logic [4:0]  frame_length;
	logic [15:0] option_flags;
	logic [7:0]  status_bits;
	logic        position_negative;
	logic [31:0] position_magnitude;
	logic [15:0] fw_version;
	logic [3:0]  hw_series;
	logic [3:0]  hw_model;
	logic [7:0]  hw_revision;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	reply_t seen;
	reply_board board;
	bit quiet = 1'b0;
	int stall_left = 0;
	int idle_cycles = 0;
	int beats = 0;
	int frames = 0;
	int settings = 0;
	int phase;
	logic [7:0] frame_q[$];
	logic [7:0] fn_menu [8] = '{FN_OPTIONS, FN_STATUS, FN_POSITION, FN_VERSION,
		FN_MOVE, FN_STOP, 8'h00, 8'hFF};
	logic [7:0] a_val;
	logic [7:0] f_val;
	logic [7:0] c_val;

	motor_reply_frame_parser_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_status(result_status),
		.reply_kind(reply_kind),
		.frame_length(frame_length),
		.option_flags(option_flags),
		.status_bits(status_bits),
		.position_negative(position_negative),
		.position_magnitude(position_magnitude),
		.fw_version(fw_version),
		.hw_series(hw_series),
		.hw_model(hw_model),
		.hw_revision(hw_revision),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	assign seen = {result_status, reply_kind, frame_length, option_flags, status_bits,
		position_negative, position_magnitude, fw_version, hw_series,
		hw_model, hw_revision};

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int pick_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 75) return $urandom_range(1, 2);
		if (p < 95) return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			if (!quiet && $urandom_range(0, 99) < 25) stall_left = pick_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) board.note_beat(data_byte, last_byte);
			if (out_valid && out_ready) board.check_reply(seen);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic send_beat(logic [7:0] b, logic l);
		int gap;
		gap = (!quiet && $urandom_range(0, 99) < 30) ? pick_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats++;
	endtask

	task automatic send_frame();
		foreach (frame_q[i]) send_beat(frame_q[i], i == frame_q.size() - 1);
		frames++;
	endtask

	// Holds the sender off until every reply is out and the pipeline has settled.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_replies.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_regs(logic [7:0] addr, logic [7:0] func, logic [7:0] tail);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ADDRESS;
		cfg_data <= addr;
		@(posedge clk);
		board.write_reg(CFG_ADDRESS, addr);
		cfg_index <= CFG_FUNCTION;
		cfg_data <= func;
		@(posedge clk);
		board.write_reg(CFG_FUNCTION, func);
		cfg_index <= CFG_CHECK;
		cfg_data <= tail;
		@(posedge clk);
		board.write_reg(CFG_CHECK, tail);
		cfg_we <= 1'b0;
		settings++;
	endtask

	function automatic void make_frame(int len, logic [7:0] b2);
		frame_q.delete();
		for (int i = 0; i < len; i++) begin
			if (i == 0) frame_q.push_back(board.dev_addr);
			else if (i == 1) frame_q.push_back(board.dev_func);
			else if (i == 2) frame_q.push_back(b2);
			else frame_q.push_back(8'($urandom));
		end
		frame_q[len - 1] = board.tail_byte;
	endfunction

	// Mostly well-formed replies for the pending function, the rest broken or noise.
	function automatic void build_frame();
		int kind;
		int len;
		int sel;
		int pos;
		logic [7:0] b2;
		kind = $urandom_range(0, 99);
		b2 = 8'($urandom);
		case (board.dev_func)
			FN_OPTIONS: len = 5;
			FN_STATUS: len = 4;
			FN_POSITION: begin
				len = 8;
				if ($urandom_range(0, 9) < 8) b2 = 8'($urandom_range(0, 1));
			end
			FN_VERSION: len = 7;
			FN_MOVE, FN_STOP: begin
				len = 4;
				case ($urandom_range(0, 2))
					0: b2 = CODE_ACK;
					1: b2 = CODE_REACH;
					default: ;
				endcase
			end
			default: len = $urandom_range(4, 8);
		endcase
		if (kind < 60) begin
			make_frame(len, b2);
		end else if (kind < 70) begin
			make_frame(4, $urandom_range(0, 1) ? CODE_PARAM : CODE_FORMAT);
		end else if (kind < 80) begin
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 9);
			make_frame(len, b2);
		end else if (kind < 90) begin
			make_frame(len, b2);
			sel = $urandom_range(0, 2);
			pos = (sel == 0) ? 0 : (sel == 1) ? 1 : len - 1;
			frame_q[pos] = frame_q[pos] ^ (8'h01 << $urandom_range(0, 7));
		end else begin
			len = $urandom_range(1, 24);
			frame_q.delete();
			repeat (len) frame_q.push_back(8'($urandom));
		end
	endfunction

	initial begin
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		frame_q = '{8'hFF};
		send_frame();
		frame_q = '{ADDRESS_RESET, FN_STATUS, 8'hBF, CHECK_RESET};
		send_frame();
		frame_q = '{ADDRESS_RESET, FN_STATUS, STATUS_RSVD, CHECK_RESET};
		send_frame();
		frame_q = '{ADDRESS_RESET, FN_STATUS, CODE_PARAM, CHECK_RESET};
		send_frame();
		frame_q = '{ADDRESS_RESET, FN_STATUS, CODE_FORMAT, CHECK_RESET};
		send_frame();
		frame_q = '{8'h00, FN_STATUS, 8'h00, CHECK_RESET};
		send_frame();
		frame_q = '{ADDRESS_RESET, FN_STATUS, 8'h00, 8'h6A};
		send_frame();
		drain();

		phase = 0;
		while (beats < TARGET_BEATS || phase < 8) begin
			if (phase == 0) begin
				a_val = 8'h00;
				c_val = 8'hFF;
			end else if (phase == 1) begin
				a_val = 8'hFF;
				c_val = 8'h00;
			end else begin
				a_val = 8'($urandom);
				c_val = 8'($urandom);
			end
			f_val = (phase >= 8 && phase % 8 == 6) ? 8'($urandom) : fn_menu[phase % 8];
			quiet = (phase % 3 == 2);
			set_regs(a_val, f_val, c_val);
			repeat (20) begin
				if ($urandom_range(0, 99) == 0) drain();
				build_frame();
				send_frame();
			end
			drain();
			phase++;
		end

		$display("Covered %0d input beats in %0d frames over %0d register settings.",
			beats, frames, settings);
		$display("Checked %0d replies: %0d ok, %0d protocol errors, %0d device errors.",
			board.checked, board.n_ok, board.n_proto, board.n_dev);
		if (board.errors == 0 && board.pending_replies.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
